// ===== hw/rtl/sssc_pkg.sv =====
// ----------------------------------------------------------------------------
// sssc_pkg
// shared widths, the count modulus and the modular add for the subset-sum
// counter
// ----------------------------------------------------------------------------
package sssc_pkg;

   localparam int COUNT_W          = 30;
   localparam int VALUE_W          = 12;
   localparam int DEF_SUM_ENTRIES  = 4096;

   localparam logic [COUNT_W:0] COUNT_MOD = (COUNT_W + 1)'(998244353);

   // both operands below the modulus, so one conditional subtract is enough
   function automatic logic [COUNT_W-1:0] add_mod(input logic [COUNT_W-1:0] x,
                                                  input logic [COUNT_W-1:0] y);
      logic [COUNT_W:0] s;
      s = {1'b0, x} + {1'b0, y};
      if (s >= COUNT_MOD) begin
         s = s - COUNT_MOD;
      end
      return s[COUNT_W-1:0];
   endfunction

endpackage

// ===== hw/rtl/sssc_row_ram.sv =====
// ----------------------------------------------------------------------------
// sssc_row_ram
// count row storage: one write port, two registered read ports
// ----------------------------------------------------------------------------
module sssc_row_ram
   import sssc_pkg::*;
#(
   parameter int SUM_ENTRIES = DEF_SUM_ENTRIES,
   localparam int AW         = $clog2(SUM_ENTRIES)
) (
   input  logic               clock,
   input  logic               wr_en,
   input  logic [AW-1:0]      wr_addr,
   input  logic [COUNT_W-1:0] wr_data,
   input  logic               rd_en,
   input  logic [AW-1:0]      rd_addr_hi,
   input  logic [AW-1:0]      rd_addr_lo,
   output logic [COUNT_W-1:0] rd_data_hi,
   output logic [COUNT_W-1:0] rd_data_lo
);

   logic [COUNT_W-1:0] mem [SUM_ENTRIES];
   logic [COUNT_W-1:0] rd_hi_ff;
   logic [COUNT_W-1:0] rd_lo_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_hi_ff <= mem[rd_addr_hi];
         rd_lo_ff <= mem[rd_addr_lo];
      end
   end

   assign rd_data_hi = rd_hi_ff;
   assign rd_data_lo = rd_lo_ff;

endmodule

// ===== hw/rtl/segment_subset_sum_counter_unit.sv =====
// ----------------------------------------------------------------------------
// segment_subset_sum_counter_unit
// counts, over all contiguous segments of a value stream, the subsets that
// sum to the target, modulo 998244353, with one row sweep per value
// ----------------------------------------------------------------------------
//
//  channel   direction  payload                                  transfer when
//  req_*     in         tdata[11:0] item_value, tlast last_item  tvalid & tready
//  rsp_*     out        tdata[29:0] running_count, tlast is_final tvalid & tready
//  csr_*     in         wr_data[11:0] target_sum                 wr_en
//
//  sequence: a value a with 1 <= a <= t (t = target, capped at SUM_ENTRIES-1)
//  sweeps entries t down to a, one row entry per cycle through the two read
//  ports and one write port of the row memory, then drains, reads row[t] and
//  emits; any other value only reads row[t] and emits. a last item then clears the row.
//  reset: a clearing pass writes zero to all SUM_ENTRIES row entries, one per
//  cycle; no item is taken until it ends, config writes are taken as ever.
//  stalls: the result register holds while rsp_tready is low; a finished item
//  waits for it to free before loading, and the next item is taken meanwhile
//  only once the block is back in idle.
// ----------------------------------------------------------------------------
module segment_subset_sum_counter_unit
   import sssc_pkg::*;
#(
   parameter int SUM_ENTRIES = DEF_SUM_ENTRIES
) (
   input  logic        clock,
   input  logic        reset,
   // config
   input  logic        csr_wr_en,
   input  logic [11:0] csr_wr_data,    // [11:0] target_sum
   // item stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,      // [11:0] item_value, [15:12] zero
   input  logic        req_tlast,      // last_item
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,      // [29:0] running_count, [31:30] zero
   output logic        rsp_tlast       // is_final
);

   localparam int AW = $clog2(SUM_ENTRIES);

   typedef enum logic [5:0] {
      ST_CLEAR  = 6'b000001,   // zero the row, one entry a cycle
      ST_IDLE   = 6'b000010,   // waiting for an item
      ST_SWEEP  = 6'b000100,   // issuing reads from t down to a
      ST_DRAIN  = 6'b001000,   // last row write lands
      ST_READ_T = 6'b010000,   // read row[t]
      ST_EMIT   = 6'b100000    // fold into total (clear it on a last item), load result register
   } state_type;

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] target_ff;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic               last_ff, last_in;
   logic [AW-1:0]      t_ff, t_in;
   logic [AW-1:0]      j_ff, j_in;
   logic [AW-1:0]      clr_ff, clr_in;
   logic [COUNT_W-1:0] index_ff, index_in;
   logic [COUNT_W-1:0] total_ff, total_in;

   // write-back stage of the sweep
   logic               wb_valid_ff, wb_valid_in;
   logic [AW-1:0]      wb_addr_ff;
   logic               wb_low_ff;     // entry j == a: add item index

   logic               rsp_valid_ff, rsp_valid_in;
   logic [COUNT_W-1:0] rsp_count_ff;
   logic               rsp_final_ff;
   logic               rsp_load;

   logic [AW-1:0]      t_eff;
   logic [VALUE_W-1:0] req_value;
   logic               req_fire;

   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   logic [COUNT_W-1:0] ram_wr_data;
   logic               ram_rd_en;
   logic [AW-1:0]      ram_rd_hi;
   logic [AW-1:0]      ram_rd_lo;
   logic [COUNT_W-1:0] ram_q_hi;
   logic [COUNT_W-1:0] ram_q_lo;
   logic [COUNT_W-1:0] wb_addend;

   assign req_value  = req_tdata[VALUE_W-1:0];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // target beyond the row saturates at the top entry
   always_comb begin
      if (32'(target_ff) > SUM_ENTRIES - 1) begin
         t_eff = AW'(SUM_ENTRIES - 1);
      end else begin
         t_eff = AW'(target_ff);
      end
   end

   // the result register frees when its transfer completes
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);

   // main sequencer
   always_comb begin
      state_in    = state_ff;
      value_in    = value_ff;
      last_in     = last_ff;
      t_in        = t_ff;
      j_in        = j_ff;
      clr_in      = clr_ff;
      index_in    = index_ff;
      total_in    = total_ff;
      wb_valid_in = 1'b0;
      ram_rd_en   = 1'b0;
      ram_rd_hi   = j_ff;
      ram_rd_lo   = j_ff - AW'(value_ff);

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(SUM_ENTRIES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               value_in = req_value;
               last_in  = req_tlast;
               t_in     = t_eff;
               j_in     = t_eff;
               index_in = add_mod(index_ff, COUNT_W'(1));
               // values of zero or above the target leave the row alone
               if ((req_value != '0) && (32'(req_value) <= 32'(t_eff))) begin
                  state_in = ST_SWEEP;
               end else begin
                  state_in = ST_READ_T;
               end
            end
         end
         ST_SWEEP: begin
            // reads run below every pending write, so no hazard on the row
            ram_rd_en   = 1'b1;
            wb_valid_in = 1'b1;
            j_in        = j_ff - AW'(1);
            if (j_ff == AW'(value_ff)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_READ_T;
         end
         ST_READ_T: begin
            ram_rd_en = 1'b1;
            ram_rd_hi = t_ff;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               if (last_ff) begin
                  // sequence done: back to an empty row
                  index_in = '0;
                  total_in = '0;
                  clr_in   = '0;
                  state_in = ST_CLEAR;
               end else begin
                  if (t_ff != '0) begin
                     total_in = add_mod(total_ff, ram_q_hi);
                  end
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   // row[0] is always zero, so at j == a the low operand is just the index
   assign wb_addend = wb_low_ff ? index_ff : ram_q_lo;

   // write port: clearing pass or sweep write-back
   always_comb begin
      if (state_ff == ST_CLEAR) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = clr_ff;
         ram_wr_data = '0;
      end else begin
         ram_wr_en   = wb_valid_ff;
         ram_wr_addr = wb_addr_ff;
         ram_wr_data = add_mod(ram_q_hi, wb_addend);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         target_ff    <= VALUE_W'(1);
         index_ff     <= '0;
         total_ff     <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         index_ff     <= index_in;
         total_ff     <= total_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            target_ff <= csr_wr_data;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      last_ff    <= last_in;
      t_ff       <= t_in;
      j_ff       <= j_in;
      wb_addr_ff <= j_ff;
      wb_low_ff  <= (j_ff == AW'(value_ff));
      if (rsp_load) begin
         // the final total includes this item's row[t]
         rsp_count_ff <= (t_ff != '0) ? add_mod(total_ff, ram_q_hi) : total_ff;
         rsp_final_ff <= last_ff;
      end
   end

   sssc_row_ram #(
      .SUM_ENTRIES (SUM_ENTRIES)
   ) u_row_ram (
      .clock      (clock),
      .wr_en      (ram_wr_en),
      .wr_addr    (ram_wr_addr),
      .wr_data    (ram_wr_data),
      .rd_en      (ram_rd_en),
      .rd_addr_hi (ram_rd_hi),
      .rd_addr_lo (ram_rd_lo),
      .rd_data_hi (ram_q_hi),
      .rd_data_lo (ram_q_lo)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_count_ff};
   assign rsp_tlast  = rsp_final_ff;

endmodule
